### rtl/core/lpfb_pkg.sv
// ----------------------------------------------------------------------------
// lpfb_pkg
// Types, codes and constants shared by the LED pixel frame buffer modules.
// ----------------------------------------------------------------------------
package lpfb_pkg;

    // request function codes
    localparam logic [2:0] FUNC_SET_RGB    = 3'd0;
    localparam logic [2:0] FUNC_SET_WRGB   = 3'd1;
    localparam logic [2:0] FUNC_SET_BRIGHT = 3'd2;
    localparam logic [2:0] FUNC_CLEAR      = 3'd3;
    localparam logic [2:0] FUNC_DUMP       = 3'd4;

    // configuration register indexes
    localparam logic REG_COLOR_ORDER = 1'b0;
    localparam logic REG_LED_COUNT   = 1'b1;

    localparam logic [7:0]  COLOR_ORDER_RESET = 8'd82;
    localparam logic [4:0]  LED_COUNT_RESET   = 5'd2;
    localparam logic [7:0]  LEVEL_MAX         = 8'hFF;
    localparam logic [15:0] FULL_SCALE        = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PIXEL,
        ST_BRIGHT,
        ST_DIV,
        ST_SCALE,
        ST_RS_RD,
        ST_RS_WR,
        ST_CLEAR,
        ST_STATUS,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } lpfb_state_t;

    // byte of a pixel written in each step, in write order
    typedef enum logic [1:0] {
        BYTE_WHITE,
        BYTE_RED,
        BYTE_GREEN,
        BYTE_BLUE
    } lpfb_byte_t;

    typedef struct packed {
        logic       load_item;
        logic       pix_write;
        lpfb_byte_t byte_sel;
        logic       rd_en;
        logic       rs_write;
        logic       div_start;
        logic       load_scale;
        logic       set_code;
        logic       clear_store;
        logic       out_status;
        logic       out_dump;
    } lpfb_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       idx_ok;
        logic       len_zero;
        logic       ptr_last;
        logic       code_same;
        logic       old_zero;
        logic       div_done;
        logic       out_free;
    } lpfb_stat_t;

    // a pixel is four bytes when the white and red offsets differ
    function automatic logic bpp_is_four(input logic [7:0] order);
        return order[7:6] != order[5:4];
    endfunction

endpackage

### rtl/core/led_pixel_frame_buffer.sv
// ----------------------------------------------------------------------------
// led_pixel_frame_buffer
// Frame store for an addressable RGB/RGBW LED string with brightness scaling.
// ----------------------------------------------------------------------------
// Takes one request at a time. A pixel write runs decode, four byte steps
// through one 8x8 scaling multiplier, and status; a clear runs decode, clear
// and status, and unused codes and pixel writes with an index outside the
// string run decode and status. A brightness change runs a serial divider for
// the rescale factor (16 quotient steps and the done flag; skipped when the old
// level is zero), then walks the store one read and one write per frame byte
// through its single memory port. A dump reads then presents each frame byte on
// that same port, a result per byte, and no result at all when the frame is empty.
// The store clears at once on reset, on a clear request and on the config
// writes that clear it, through per-byte valid bits; there is no clearing
// pass. Registers: 0x0 color_order, 0x4 led_count (low five bits; values above
// MAX_LEDS read back as MAX_LEDS).
// ----------------------------------------------------------------------------
module led_pixel_frame_buffer #(
    parameter int MAX_LEDS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_pixel_index,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_white,
    input  logic [7:0]  s_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_last_byte,
    output logic [7:0]  m_brightness_now,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lpfb_pkg::lpfb_cmd_t  cmd;
    lpfb_pkg::lpfb_stat_t stat;

    logic [7:0] color_order_reg, color_order_next;
    logic [4:0] led_count_reg, led_count_next;
    logic       cfg_write;
    logic       store_clear;
    logic [4:0] count_in;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        color_order_next = color_order_reg;
        led_count_next   = led_count_reg;
        store_clear      = 1'b0;
        count_in = (pwdata[4:0] > 5'(MAX_LEDS)) ? 5'(MAX_LEDS) : pwdata[4:0];
        if (cfg_write) begin
            unique case (paddr[2])
                lpfb_pkg::REG_COLOR_ORDER: begin
                    color_order_next = pwdata[7:0];
                    // a change of pixel size drops the frame
                    store_clear = lpfb_pkg::bpp_is_four(pwdata[7:0])
                               != lpfb_pkg::bpp_is_four(color_order_reg);
                end
                lpfb_pkg::REG_LED_COUNT: begin
                    led_count_next = count_in;
                    store_clear    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_order_reg <= lpfb_pkg::COLOR_ORDER_RESET;
            led_count_reg   <= lpfb_pkg::LED_COUNT_RESET;
        end else begin
            color_order_reg <= color_order_next;
            led_count_reg   <= led_count_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            lpfb_pkg::REG_COLOR_ORDER: prdata = {24'h0, color_order_reg};
            lpfb_pkg::REG_LED_COUNT:   prdata = {27'h0, led_count_reg};
            default:                   prdata = 32'h0;
        endcase
    end

    lpfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lpfb_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .color_order      (color_order_reg),
        .led_count        (led_count_reg),
        .store_clear      (store_clear),
        .s_func           (s_func),
        .s_pixel_index    (s_pixel_index),
        .s_red            (s_red),
        .s_green          (s_green),
        .s_blue           (s_blue),
        .s_white          (s_white),
        .s_level          (s_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_byte     (m_frame_byte),
        .m_last_byte      (m_last_byte),
        .m_brightness_now (m_brightness_now)
    );

    // a result is only loaded when the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_status || cmd.out_dump) |-> stat.out_free)
        else $error("result loaded over a waiting result");

    // brightness code only moves when the level differs
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_code |-> !stat.code_same)
        else $error("brightness code set to its own value");

    // pixel bytes are only written for an index inside the string
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pix_write |-> stat.idx_ok)
        else $error("pixel write for an index out of range");

endmodule

### rtl/core/lpfb_divider.sv
// ----------------------------------------------------------------------------
// lpfb_divider
// Restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lpfb_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  div_reg, div_next;
    logic [8:0]  shifted;
    logic [8:0]  diff;
    logic        fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[15]};
        diff    = shifted - {1'b0, div_reg};
        fits    = shifted >= {1'b0, div_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[7:0] : shifted[7:0];
            quo_next = {quo_reg[14:0], fits};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'hF) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/lpfb_datapath.sv
// ----------------------------------------------------------------------------
// lpfb_datapath
// Request latch, byte store with valid bits, scaling, divider and result register.
// ----------------------------------------------------------------------------
module lpfb_datapath #(
    parameter int MAX_LEDS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpfb_pkg::lpfb_cmd_t  cmd,
    output lpfb_pkg::lpfb_stat_t stat,
    input  logic [7:0]           color_order,
    input  logic [4:0]           led_count,
    input  logic                 store_clear,
    input  logic [2:0]           s_func,
    input  logic [15:0]          s_pixel_index,
    input  logic [7:0]           s_red,
    input  logic [7:0]           s_green,
    input  logic [7:0]           s_blue,
    input  logic [7:0]           s_white,
    input  logic [7:0]           s_level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_frame_byte,
    output logic                 m_last_byte,
    output logic [7:0]           m_brightness_now
);

    localparam int STORE_BYTES = MAX_LEDS * 4;
    localparam int AW = $clog2(STORE_BYTES);
    localparam int LW = $clog2(STORE_BYTES + 1);
    localparam int IW = $clog2(MAX_LEDS + 1);

    // latched request
    logic [2:0]    func_reg;
    logic [IW-1:0] idx_reg;
    logic          idx_ok_reg;
    logic [7:0]    red_reg, green_reg, blue_reg, white_reg, level_reg;

    logic [LW-1:0] ptr_reg;
    logic [LW-1:0] ptr_inc;
    logic [7:0]    code_reg;
    logic [15:0]   scale_reg;

    logic [7:0]    mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] valid_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_valid_reg;
    logic [7:0]    rd_byte;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic [7:0]    out_bright_reg;

    logic          bpp4;
    logic [6:0]    len_full;
    logic [LW-1:0] frame_len;
    logic [LW-1:0] base;
    logic [1:0]    offset;
    logic [LW-1:0] pix_addr;
    logic [7:0]    pix_val;
    logic [15:0]   pix_prod;
    logic [7:0]    pix_scaled;
    logic          pix_used;
    logic [23:0]   rs_prod;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    fresh;
    logic [7:0]    old;
    logic [15:0]   dividend;
    logic          div_done;
    logic [15:0]   div_quotient;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg   <= s_func;
            idx_reg    <= s_pixel_index[IW-1:0];
            idx_ok_reg <= s_pixel_index < {11'b0, led_count};
            red_reg    <= s_red;
            green_reg  <= s_green;
            blue_reg   <= s_blue;
            white_reg  <= s_white;
            level_reg  <= s_level;
        end
    end

    // frame geometry
    always_comb begin
        bpp4      = lpfb_pkg::bpp_is_four(color_order);
        len_full  = bpp4 ? {led_count, 2'b00}
                         : ({2'b00, led_count} + {1'b0, led_count, 1'b0});
        frame_len = LW'(len_full);
        ptr_inc   = ptr_reg + LW'(1);
    end

    // pixel byte step
    always_comb begin
        base = bpp4 ? LW'({idx_reg, 2'b00})
                    : (LW'({idx_reg, 1'b0}) + LW'(idx_reg));
        case (cmd.byte_sel)
            lpfb_pkg::BYTE_WHITE: begin
                offset  = color_order[7:6];
                pix_val = (func_reg == lpfb_pkg::FUNC_SET_WRGB) ? white_reg : 8'h00;
            end
            lpfb_pkg::BYTE_RED: begin
                offset  = color_order[5:4];
                pix_val = red_reg;
            end
            lpfb_pkg::BYTE_GREEN: begin
                offset  = color_order[3:2];
                pix_val = green_reg;
            end
            default: begin
                offset  = color_order[1:0];
                pix_val = blue_reg;
            end
        endcase
        pix_addr   = base + LW'(offset);
        pix_prod   = pix_val * code_reg;
        pix_scaled = (code_reg == 8'h00) ? pix_val : pix_prod[15:8];
        pix_used   = bpp4 || (cmd.byte_sel != lpfb_pkg::BYTE_WHITE);
    end

    // rescale and write port selection
    always_comb begin
        rd_byte = rd_valid_reg ? rd_data_reg : 8'h00;
        rs_prod = rd_byte * scale_reg;
        wr_en   = cmd.rs_write || (cmd.pix_write && pix_used && (pix_addr < frame_len));
        wr_addr = cmd.rs_write ? ptr_reg[AW-1:0] : pix_addr[AW-1:0];
        wr_data = cmd.rs_write ? rs_prod[15:8] : pix_scaled;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[ptr_reg[AW-1:0]];
            rd_valid_reg <= valid_reg[ptr_reg[AW-1:0]];
        end
    end

    // an entry that is not valid reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.clear_store || store_clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (cmd.load_item) begin
            ptr_reg <= '0;
        end else if (cmd.rs_write || cmd.out_dump) begin
            ptr_reg <= ptr_inc;
        end
    end

    // brightness
    always_comb begin
        fresh    = level_reg + 8'd1;
        old      = code_reg - 8'd1;
        dividend = (level_reg == lpfb_pkg::LEVEL_MAX) ? lpfb_pkg::FULL_SCALE
                                                      : ({fresh, 8'h00} - 16'd1);
    end

    lpfb_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (old),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= 8'h00;
        end else if (cmd.set_code) begin
            code_reg <= fresh;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_scale) begin
            scale_reg <= (old == 8'h00) ? 16'h0000 : div_quotient;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_status || cmd.out_dump) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_status) begin
            out_byte_reg   <= 8'h00;
            out_last_reg   <= 1'b0;
            out_bright_reg <= code_reg - 8'd1;
        end else if (cmd.out_dump) begin
            out_byte_reg   <= rd_byte;
            out_last_reg   <= ptr_inc == frame_len;
            out_bright_reg <= code_reg - 8'd1;
        end
    end

    always_comb begin
        stat.func      = func_reg;
        stat.idx_ok    = idx_ok_reg;
        stat.len_zero  = frame_len == '0;
        stat.ptr_last  = ptr_inc == frame_len;
        stat.code_same = fresh == code_reg;
        stat.old_zero  = old == 8'h00;
        stat.div_done  = div_done;
        stat.out_free  = !out_valid_reg || m_ready;
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_byte     = out_byte_reg;
    assign m_last_byte      = out_last_reg;
    assign m_brightness_now = out_bright_reg;

endmodule

### rtl/core/lpfb_ctrl.sv
// ----------------------------------------------------------------------------
// lpfb_ctrl
// Sequencer for pixel writes, brightness rescale, clear and frame dump.
// ----------------------------------------------------------------------------
module lpfb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpfb_pkg::lpfb_stat_t stat,
    output lpfb_pkg::lpfb_cmd_t  cmd
);

    lpfb_pkg::lpfb_state_t state_reg, state_next;
    lpfb_pkg::lpfb_byte_t  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpfb_pkg::ST_IDLE;
            step_reg  <= lpfb_pkg::BYTE_WHITE;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = lpfb_pkg::BYTE_WHITE;
        unique case (state_reg)
            lpfb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lpfb_pkg::ST_DECODE;
                end
            end
            lpfb_pkg::ST_DECODE: begin
                unique case (stat.func) inside
                    lpfb_pkg::FUNC_SET_RGB, lpfb_pkg::FUNC_SET_WRGB: begin
                        state_next = stat.idx_ok ? lpfb_pkg::ST_PIXEL : lpfb_pkg::ST_STATUS;
                    end
                    lpfb_pkg::FUNC_SET_BRIGHT: state_next = lpfb_pkg::ST_BRIGHT;
                    lpfb_pkg::FUNC_CLEAR:      state_next = lpfb_pkg::ST_CLEAR;
                    lpfb_pkg::FUNC_DUMP: begin
                        state_next = stat.len_zero ? lpfb_pkg::ST_IDLE : lpfb_pkg::ST_DUMP_RD;
                    end
                    default:                   state_next = lpfb_pkg::ST_STATUS;
                endcase
            end
            lpfb_pkg::ST_PIXEL: begin
                step_next = lpfb_pkg::lpfb_byte_t'(step_reg + 2'd1);
                if (step_reg == lpfb_pkg::BYTE_BLUE) begin
                    state_next = lpfb_pkg::ST_STATUS;
                end
            end
            lpfb_pkg::ST_BRIGHT: begin
                if (stat.code_same) begin
                    state_next = lpfb_pkg::ST_STATUS;
                end else if (stat.old_zero) begin
                    state_next = lpfb_pkg::ST_SCALE;
                end else begin
                    state_next = lpfb_pkg::ST_DIV;
                end
            end
            lpfb_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    state_next = lpfb_pkg::ST_SCALE;
                end
            end
            lpfb_pkg::ST_SCALE: begin
                state_next = stat.len_zero ? lpfb_pkg::ST_STATUS : lpfb_pkg::ST_RS_RD;
            end
            lpfb_pkg::ST_RS_RD:    state_next = lpfb_pkg::ST_RS_WR;
            lpfb_pkg::ST_RS_WR: begin
                state_next = stat.ptr_last ? lpfb_pkg::ST_STATUS : lpfb_pkg::ST_RS_RD;
            end
            lpfb_pkg::ST_CLEAR:    state_next = lpfb_pkg::ST_STATUS;
            lpfb_pkg::ST_STATUS: begin
                if (stat.out_free) begin
                    state_next = lpfb_pkg::ST_IDLE;
                end
            end
            lpfb_pkg::ST_DUMP_RD:  state_next = lpfb_pkg::ST_DUMP_OUT;
            lpfb_pkg::ST_DUMP_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.ptr_last ? lpfb_pkg::ST_IDLE : lpfb_pkg::ST_DUMP_RD;
                end
            end
            default:               state_next = lpfb_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.byte_sel = step_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            lpfb_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            lpfb_pkg::ST_PIXEL:   cmd.pix_write = 1'b1;
            lpfb_pkg::ST_BRIGHT: begin
                cmd.div_start  = !stat.code_same && !stat.old_zero;
                cmd.load_scale = !stat.code_same && stat.old_zero;
            end
            lpfb_pkg::ST_DIV:     cmd.load_scale = stat.div_done;
            lpfb_pkg::ST_SCALE:   cmd.set_code = stat.len_zero;
            lpfb_pkg::ST_RS_RD:   cmd.rd_en = 1'b1;
            lpfb_pkg::ST_RS_WR: begin
                cmd.rs_write = 1'b1;
                cmd.set_code = stat.ptr_last;
            end
            lpfb_pkg::ST_CLEAR:   cmd.clear_store = 1'b1;
            lpfb_pkg::ST_STATUS:  cmd.out_status = stat.out_free;
            lpfb_pkg::ST_DUMP_RD: cmd.rd_en = 1'b1;
            lpfb_pkg::ST_DUMP_OUT: cmd.out_dump = stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

### tb/led_pixel_frame_buffer_checker.sv
// ----------------------------------------------------------------------------
// led_pixel_frame_buffer_checker
// Watches the request, result and register ports of the LED frame buffer,
// keeps its own copy of the frame store and brightness, and compares every
// result against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module led_pixel_frame_buffer_checker #(
    parameter int MAX_LEDS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_pixel_index,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_white,
    input  logic [7:0]  s_level,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_frame_byte,
    input  logic        m_last_byte,
    input  logic [7:0]  m_brightness_now,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatch_count,
    output int          results_checked,
    output int          owed_count
);
    import lpfb_pkg::*;

    localparam int STORE_BYTES = MAX_LEDS * 4;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [7:0] brightness_now;
    } strip_word_t;

    logic [7:0]  strip_order;
    int unsigned strip_pixels;
    logic [7:0]  frame_mem [STORE_BYTES];
    logic [7:0]  dim_code;
    strip_word_t strip_words_due [$];
    int          errors = 0;
    int          words_checked = 0;

    function automatic int unsigned pixel_bytes(input logic [7:0] order);
        return (order[7:6] == order[5:4]) ? 3 : 4;
    endfunction

    function automatic int unsigned frame_bytes();
        return strip_pixels * pixel_bytes(strip_order);
    endfunction

    function automatic void clear_store();
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    endfunction

    function automatic logic [7:0] dimmed(input logic [7:0] v);
        logic [15:0] prod;
        if (dim_code == 8'h00) return v;
        prod = v * dim_code;
        return prod[15:8];
    endfunction

    function automatic void store_byte(input int unsigned addr, input logic [7:0] v);
        if (addr < frame_bytes() && addr < STORE_BYTES) frame_mem[addr] = v;
    endfunction

    // write order is white, red, green, blue: with equal offsets the later byte wins
    function automatic void paint_pixel(input logic [15:0] n, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [7:0] w);
        int unsigned bpp;
        int unsigned base;
        bpp = pixel_bytes(strip_order);
        if (n >= strip_pixels) return;
        base = n * bpp;
        if (bpp == 4) store_byte(base + strip_order[7:6], dimmed(w));
        store_byte(base + strip_order[5:4], dimmed(r));
        store_byte(base + strip_order[3:2], dimmed(g));
        store_byte(base + strip_order[1:0], dimmed(b));
    endfunction

    function automatic void change_brightness(input logic [7:0] level);
        logic [7:0]  fresh;
        logic [7:0]  old;
        logic [15:0] factor;
        logic [23:0] prod;
        int unsigned len;
        fresh = level + 8'd1;
        old = dim_code - 8'd1;
        if (fresh == dim_code) return;
        if (old == 8'h00) factor = 16'h0000;
        else if (level == LEVEL_MAX) factor = FULL_SCALE / old;
        else factor = ({fresh, 8'h00} - 16'd1) / old;
        len = frame_bytes();
        for (int i = 0; i < len && i < STORE_BYTES; i++) begin
            prod = frame_mem[i] * factor;
            frame_mem[i] = prod[15:8];
        end
        dim_code = fresh;
    endfunction

    function automatic void expect_outcome(input logic [2:0] func, input logic [15:0] idx,
                                           input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [7:0] w,
                                           input logic [7:0] level);
        strip_word_t word;
        int unsigned len;
        len = frame_bytes();
        if (func == FUNC_DUMP) begin
            // empty frame gives nothing back
            for (int i = 0; i < len && i < STORE_BYTES; i++) begin
                word.frame_byte = frame_mem[i];
                word.last_byte = (i + 1 == len);
                word.brightness_now = dim_code - 8'd1;
                strip_words_due.push_back(word);
            end
            return;
        end
        case (func)
            FUNC_SET_RGB:    paint_pixel(idx, r, g, b, 8'h00);
            FUNC_SET_WRGB:   paint_pixel(idx, r, g, b, w);
            FUNC_SET_BRIGHT: change_brightness(level);
            FUNC_CLEAR:      clear_store();
            default: ;
        endcase
        word.frame_byte = 8'h00;
        word.last_byte = 1'b0;
        word.brightness_now = dim_code - 8'd1;
        strip_words_due.push_back(word);
    endfunction

    function automatic void write_register(input logic reg_sel, input logic [31:0] value);
        logic [7:0]  next_order;
        int unsigned n;
        if (reg_sel == REG_COLOR_ORDER) begin
            next_order = value[7:0];
            if (pixel_bytes(next_order) != pixel_bytes(strip_order)) clear_store();
            strip_order = next_order;
        end else begin
            n = value[4:0];
            if (n > MAX_LEDS) n = MAX_LEDS;
            strip_pixels = n;
            clear_store();
        end
    endfunction

    always @(posedge aclk) begin
        strip_word_t want;
        if (!aresetn) begin
            strip_order = COLOR_ORDER_RESET;
            strip_pixels = LED_COUNT_RESET;
            dim_code = 8'h00;
            clear_store();
            strip_words_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) write_register(paddr[2], pwdata);
            if (m_valid && m_ready) begin
                if (strip_words_due.size() == 0) begin
                    errors++;
                    $error("unexpected result: frame_byte %0d last_byte %0d brightness_now %0d",
                           m_frame_byte, m_last_byte, m_brightness_now);
                end else begin
                    want = strip_words_due.pop_front();
                    words_checked++;
                    if (m_frame_byte !== want.frame_byte) begin
                        errors++;
                        $error("frame_byte: expected %0d, got %0d",
                               want.frame_byte, m_frame_byte);
                    end
                    if (m_last_byte !== want.last_byte) begin
                        errors++;
                        $error("last_byte: expected %0d, got %0d",
                               want.last_byte, m_last_byte);
                    end
                    if (m_brightness_now !== want.brightness_now) begin
                        errors++;
                        $error("brightness_now: expected %0d, got %0d",
                               want.brightness_now, m_brightness_now);
                    end
                end
            end
            if (s_valid && s_ready)
                expect_outcome(s_func, s_pixel_index, s_red, s_green, s_blue, s_white,
                               s_level);
        end
        owed_count <= strip_words_due.size();
        mismatch_count <= errors;
        results_checked <= words_checked;
    end

endmodule

### tb/led_pixel_frame_buffer_test.sv
// ----------------------------------------------------------------------------
// led_pixel_frame_buffer_test
// Drives pixel, brightness, clear and dump requests into the LED frame buffer
// under a series of color-order and LED-count settings, with random idling on
// both channels and one long output stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
module led_pixel_frame_buffer_test;
    import lpfb_pkg::*;

    localparam int LIMIT_CYCLES    = 1000000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 12;
    localparam int PHASE_REQUESTS  = 28;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = FUNC_CLEAR;
    logic [15:0] s_pixel_index = 16'h0000;
    logic [7:0]  s_red = 8'h00;
    logic [7:0]  s_green = 8'h00;
    logic [7:0]  s_blue = 8'h00;
    logic [7:0]  s_white = 8'h00;
    logic [7:0]  s_level = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_frame_byte;
    logic        m_last_byte;
    logic [7:0]  m_brightness_now;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          results_checked;
    int          owed_count;

    int          gap_cap_src = 5;
    int          gap_cap_snk = 5;
    bit          hold_off_pending = 1'b0;
    int unsigned strip_len = LED_COUNT_RESET;
    logic [7:0]  last_level = LEVEL_MAX;
    int unsigned requests_sent = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    led_pixel_frame_buffer #(
        .MAX_LEDS(16)
    ) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_pixel_index(s_pixel_index), .s_red(s_red), .s_green(s_green),
        .s_blue(s_blue), .s_white(s_white), .s_level(s_level),
        .m_valid(m_valid), .m_ready(m_ready), .m_frame_byte(m_frame_byte),
        .m_last_byte(m_last_byte), .m_brightness_now(m_brightness_now),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    led_pixel_frame_buffer_checker #(
        .MAX_LEDS(16)
    ) frame_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_pixel_index(s_pixel_index), .s_red(s_red), .s_green(s_green),
        .s_blue(s_blue), .s_white(s_white), .s_level(s_level),
        .m_valid(m_valid), .m_ready(m_ready), .m_frame_byte(m_frame_byte),
        .m_last_byte(m_last_byte), .m_brightness_now(m_brightness_now),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatch_count(mismatch_count), .results_checked(results_checked),
        .owed_count(owed_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("led_pixel_frame_buffer_test: done, errors");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            gap = $urandom_range(0, gap_cap_snk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic offer(input logic [2:0] func, input logic [15:0] idx,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic [7:0] w, input logic [7:0] level);
        int gap;
        gap = $urandom_range(0, gap_cap_src);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_pixel_index <= idx;
        s_red <= r;
        s_green <= g;
        s_blue <= b;
        s_white <= w;
        s_level <= level;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (func == FUNC_SET_BRIGHT) last_level = level;
    endtask

    // drop valid, drain every owed result, then let a trailing empty dump finish
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (owed_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [7:0] pick_color();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_request();
        logic [2:0]  func;
        logic [15:0] idx;
        logic [7:0]  level;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) func = FUNC_SET_RGB;
        else if (pick < 58) func = FUNC_SET_WRGB;
        else if (pick < 72) func = FUNC_SET_BRIGHT;
        else if (pick < 86) func = FUNC_DUMP;
        else if (pick < 93) func = FUNC_CLEAR;
        else func = FUNC_DUMP + 3'($urandom_range(1, 3));
        pick = $urandom_range(0, 9);
        if (pick < 7) idx = (strip_len == 0) ? 16'd0 : 16'($urandom_range(0, strip_len - 1));
        else if (pick == 7) idx = 16'(strip_len);
        else idx = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        if (pick == 0) level = LEVEL_MAX;
        else if (pick == 1) level = 8'h00;
        else if (pick == 2) level = last_level;
        else level = 8'($urandom_range(0, 255));
        offer(func, idx, pick_color(), pick_color(), pick_color(), pick_color(), level);
    endtask

    initial begin
        logic [7:0]  order;
        int unsigned count;
        bit          wr_count;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset layout: RGB, two pixels, no scaling
        offer(FUNC_DUMP, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        offer(FUNC_SET_RGB, 16'd0, 8'hFF, 8'h00, 8'hAA, 8'hFF, 8'h00);
        offer(FUNC_SET_WRGB, 16'd1, 8'h00, 8'hFF, 8'h55, 8'hFF, 8'hFF);
        offer(FUNC_SET_RGB, 16'd2, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00);
        offer(FUNC_SET_RGB, 16'hFFFF, 8'h77, 8'h88, 8'h99, 8'h00, 8'h00);
        offer(FUNC_DUMP, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        offer(FUNC_SET_BRIGHT, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'd127);
        offer(FUNC_SET_RGB, 16'd0, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h00);
        offer(FUNC_SET_BRIGHT, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'd127);
        // full brightness: the rescale factor overflows a byte
        offer(FUNC_SET_BRIGHT, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, LEVEL_MAX);
        offer(FUNC_DUMP, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        offer(FUNC_SET_BRIGHT, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        offer(FUNC_SET_BRIGHT, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // old level zero gives a zero factor
        offer(FUNC_SET_BRIGHT, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
        offer(FUNC_SET_WRGB, 16'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        offer(FUNC_SET_BRIGHT, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, LEVEL_MAX);
        offer(FUNC_SET_RGB, 16'd0, 8'hC3, 8'h3C, 8'h5A, 8'h00, 8'h00);
        offer(FUNC_DUMP, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        offer(FUNC_CLEAR, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        offer(FUNC_DUMP, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        offer(FUNC_DUMP + 3'd1, 16'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        offer(FUNC_DUMP + 3'd2, 16'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        offer(FUNC_DUMP + 3'd3, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin order = 8'hE4; count = 16; wr_count = 1'b1; end
                // same pixel width: the store survives the order change
                1: begin order = 8'h1B; count = 0; wr_count = 1'b0; end
                // offset 3 in RGB form spills into the next pixel
                2: begin order = 8'hFF; count = 31; wr_count = 1'b1; end
                3: begin order = 8'h00; count = 0; wr_count = 1'b0; end
                4: begin order = 8'h93; count = 0; wr_count = 1'b1; end
                5: begin order = 8'h52; count = 1; wr_count = 1'b1; end
                6: begin order = 8'h6C; count = 7; wr_count = 1'b1; end
                default: begin
                    order = 8'($urandom_range(0, 255));
                    count = $urandom_range(0, 31);
                    wr_count = ($urandom_range(0, 3) != 0);
                end
            endcase
            write_reg(REG_COLOR_ORDER, {24'h0, order});
            if (wr_count) begin
                write_reg(REG_LED_COUNT, count);
                strip_len = (count > 16) ? 16 : count;
            end
            settings_used++;
            gap_cap_src = (p % 4 == 3) ? 0 : 5;
            gap_cap_snk = (p % 4 == 3) ? 0 : 5;
            // long output stall while requests keep coming
            if (p == 0) hold_off_pending = 1'b1;
            offer(FUNC_DUMP, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            repeat (PHASE_REQUESTS) random_request();
            settle();
        end

        $display("summary: %0d requests under %0d register settings, %0d results compared",
                 requests_sent, settings_used, results_checked);
        $display("summary: rgb and rgbw layouts, rescale, clear, dumps, one %0d-cycle stall",
                 HOLD_OFF_CYCLES);
        if (mismatch_count == 0) begin
            $display("led_pixel_frame_buffer_test: done, clean");
        end else begin
            $display("led_pixel_frame_buffer_test: done, errors");
        end
        $finish;
    end

endmodule
